FILE: src/aes128_pkg.sv
// Package with the types, tables and round functions of the AES-128 block cipher.
package aes128_pkg;

  typedef struct packed {
    logic        cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } out_item_t;

  typedef struct packed {
    logic         dec;
    logic [127:0] st;
  } pipe_t;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam int unsigned NumRounds = 10;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] subst_state(logic [127:0] s, logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      o[8*i +: 8] = inv ? SBOX_INV[s[8*i +: 8]] : SBOX_FWD[s[8*i +: 8]];
    end
    return o;
  endfunction

  // Byte i of the state sits in bits 127-8i down to 120-8i.
  function automatic logic [127:0] rotate_rows(logic [127:0] s, logic inv);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = inv ? s[127-8*((4*c+13*r)%16) -: 8]
                                    : s[127-8*((4*c+5*r)%16) -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_state(logic [127:0] s, logic inv);
    logic [127:0] o;
    logic [7:0]   b [4];
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    logic [7:0]   m3 [4];
    logic [7:0]   m9 [4];
    logic [7:0]   mb [4];
    logic [7:0]   md [4];
    logic [7:0]   me [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        b[k]  = s[127-8*(4*c+k) -: 8];
        x2[k] = xtime(b[k]);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
        m3[k] = x2[k] ^ b[k];
        m9[k] = x8[k] ^ b[k];
        mb[k] = x8[k] ^ x2[k] ^ b[k];
        md[k] = x8[k] ^ x4[k] ^ b[k];
        me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          o[127-8*(4*c+r) -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
        end else begin
          o[127-8*(4*c+r) -: 8] = x2[r] ^ m3[(r+1)%4] ^ b[(r+2)%4] ^ b[(r+3)%4];
        end
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] next_round_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX_FWD[w3[23:16]] ^ rc, SBOX_FWD[w3[15:8]], SBOX_FWD[w3[7:0]],
          SBOX_FWD[w3[31:24]]};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

FILE: src/aes128_round.sv
// One registered cipher round, serving encryption and decryption alike.
module aes128_round #(
  parameter bit LastRound = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  aes128_pkg::pipe_t     pipe_i,
  input  logic [127:0]          rk_enc_i,
  input  logic [127:0]          rk_dec_i,
  output logic                  valid_o,
  output aes128_pkg::pipe_t     pipe_o
);

  logic               valid_q;
  aes128_pkg::pipe_t  pipe_d, pipe_q;
  logic [127:0]       sub_st;
  logic [127:0]       enc_st;
  logic [127:0]       dec_st;

  always_comb begin
    sub_st = aes128_pkg::subst_state(aes128_pkg::rotate_rows(pipe_i.st, pipe_i.dec), pipe_i.dec);
    if (LastRound) begin
      enc_st = sub_st ^ rk_enc_i;
      dec_st = sub_st ^ rk_dec_i;
    end else begin
      enc_st = aes128_pkg::mix_state(sub_st, 1'b0) ^ rk_enc_i;
      dec_st = aes128_pkg::mix_state(sub_st ^ rk_dec_i, 1'b1);
    end
    pipe_d.dec = pipe_i.dec;
    pipe_d.st  = (pipe_i.dec == aes128_pkg::CMD_DECRYPT) ? dec_st : enc_st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

FILE: src/aes128_block_cipher.sv
// Top level of the pipelined AES-128 block cipher with its key expansion.
//
//   Channel   Ports                              Handshake
//   input     start_i, data_i                    accepted when start_i and not busy_o
//   result    done_o, result_o                   valid for one cycle, cannot be held off
//   config    cfg_we_i, cfg_addr_i, cfg_wdata_i  written on every cycle with cfg_we_i
//
// One item is accepted per cycle while busy_o is low; each result passes through a register
// for the initial key addition and one for each of the ten rounds.
// After reset and after every key write, busy_o stays high while the round keys
// are expanded one per cycle into registers.
// The receiver cannot stall, so the pipeline never holds.
module aes128_block_cipher (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  aes128_pkg::in_item_t     data_i,
  output logic                     busy_o,
  output logic                     done_o,
  output aes128_pkg::out_item_t    result_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_addr_i,
  input  logic [63:0]              cfg_wdata_i
);

  localparam logic [3:0] ExpLoad = 4'd0;
  localparam logic [3:0] ExpDone = 4'd11;

  logic [63:0]  key_high_q, key_low_q;
  logic [3:0]   exp_cnt_q;
  logic [127:0] wk_q;
  logic [127:0] wk_next;
  logic [7:0]   rc_q;
  logic [127:0] rk_q [1:10];
  logic [127:0] rk [0:10];

  logic               accept;
  logic               valid [0:10];
  aes128_pkg::pipe_t  pipe [0:10];
  aes128_pkg::pipe_t  pipe0_q;
  logic               valid0_q;
  logic [127:0]       blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        aes128_pkg::REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        aes128_pkg::REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign wk_next = aes128_pkg::next_round_key(wk_q, rc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_cnt_q <= ExpLoad;
    end else if (cfg_we_i) begin
      exp_cnt_q <= ExpLoad;
    end else if (exp_cnt_q != ExpDone) begin
      exp_cnt_q <= exp_cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exp_cnt_q == ExpLoad) begin
      wk_q <= {key_high_q, key_low_q};
      rc_q <= 8'h01;
    end else if (exp_cnt_q != ExpDone) begin
      wk_q <= wk_next;
      rc_q <= aes128_pkg::xtime(rc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 1; i <= 10; i++) begin
      if (exp_cnt_q == 4'(i)) begin
        rk_q[i] <= wk_next;
      end
    end
  end

  for (genvar g = 1; g <= 10; g++) begin : g_rk
    assign rk[g] = rk_q[g];
  end
  assign rk[0] = {key_high_q, key_low_q};

  assign busy_o = (exp_cnt_q != ExpDone);
  assign accept = start_i && !busy_o;
  assign blk    = {data_i.block_high, data_i.block_low};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else begin
      valid0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pipe0_q.dec <= data_i.cmd;
      pipe0_q.st  <= blk ^ ((data_i.cmd == aes128_pkg::CMD_DECRYPT) ? rk[10] : rk[0]);
    end
  end

  assign valid[0] = valid0_q;
  assign pipe[0]  = pipe0_q;

  for (genvar j = 1; j <= 10; j++) begin : g_round
    aes128_round #(
      .LastRound(j == 10)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[j-1]),
      .pipe_i  (pipe[j-1]),
      .rk_enc_i(rk[j]),
      .rk_dec_i(rk[10-j]),
      .valid_o (valid[j]),
      .pipe_o  (pipe[j])
    );
  end

  assign done_o            = valid[10];
  assign result_o.out_high = pipe[10].st[127:64];
  assign result_o.out_low  = pipe[10].st[63:0];

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the AES-128 block cipher: directed vectors, random blocks, key changes.
module tb;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  aes128_pkg::in_item_t  data_i;
  logic                  busy_o;
  logic                  done_o;
  aes128_pkg::out_item_t result_o;
  logic                  cfg_we_i;
  logic                  cfg_addr_i;
  logic [63:0]           cfg_wdata_i;

  aes128_block_cipher u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .data_i(data_i),
    .busy_o(busy_o), .done_o(done_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_wdata_i(cfg_wdata_i)
  );

  int unsigned n_errors;
  int unsigned n_blocks;
  int unsigned n_enc;
  int unsigned n_dec;
  longint unsigned cycles;
  logic [63:0] key_hi;
  logic [63:0] key_lo;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    n_errors++;
  endtask

  function automatic logic [7:0] gf_x2(logic [7:0] a);
    logic [7:0] r;
    r = {a[6:0], 1'b0};
    if (a[7]) r = r ^ 8'h1b;
    return r;
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = gf_x2(a);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(logic [7:0] x);
    logic [7:0] r;
    logic [7:0] base;
    int e;
    r = 8'h01;
    base = x;
    e = 254;
    while (e != 0) begin
      if (e & 1) r = gf_mul(r, base);
      base = gf_mul(base, base);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sub(logic [7:0] y);
    return gf_inv(rol8(y, 1) ^ rol8(y, 3) ^ rol8(y, 6) ^ 8'h05);
  endfunction

  function automatic aes128_pkg::out_item_t cipher_block(aes128_pkg::in_item_t it,
                                                         logic [63:0] kh, logic [63:0] kl);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] w0;
    logic [7:0] rc;
    logic [7:0] acc;
    logic [7:0] mf [4];
    logic [7:0] mi [4];
    logic [7:0] m [4];
    aes128_pkg::out_item_t o;
    bit dec;
    mf = '{8'h02, 8'h03, 8'h01, 8'h01};
    mi = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    dec = it.cmd == aes128_pkg::CMD_DECRYPT;
    if (dec) m = mi;
    else m = mf;
    for (int i = 0; i < 8; i++) begin
      rk[i] = kh[63-8*i -: 8];
      rk[8+i] = kl[63-8*i -: 8];
      s[i] = it.block_high[63-8*i -: 8];
      s[8+i] = it.block_low[63-8*i -: 8];
    end
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        w0 = w[0];
        w[0] = fwd_sub(w[1]) ^ rc;
        w[1] = fwd_sub(w[2]);
        w[2] = fwd_sub(w[3]);
        w[3] = fwd_sub(w0);
        rc = gf_x2(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[dec ? 160 + i : i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      t = s;
      for (int c = 0; c < 4; c++) begin
        for (int r = 1; r < 4; r++) begin
          s[4*c+r] = t[(4*c + (dec ? 13 : 5)*r) % 16];
        end
      end
      for (int i = 0; i < 16; i++) s[i] = dec ? inv_sub(s[i]) : fwd_sub(s[i]);
      if (dec) begin
        for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16*(10-rnd) + i];
      end
      if (rnd < 10) begin
        t = s;
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) acc = acc ^ gf_mul(t[4*c+k], m[(k-r+4)%4]);
            s[4*c+r] = acc;
          end
        end
      end
      if (!dec) begin
        for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16*rnd + i];
      end
    end
    for (int i = 0; i < 8; i++) begin
      o.out_high[63-8*i -: 8] = s[i];
      o.out_low[63-8*i -: 8] = s[8+i];
    end
    return o;
  endfunction

  class cipher_scoreboard;
    aes128_pkg::out_item_t pending_blocks[$];

    function void note_block(aes128_pkg::in_item_t it, logic [63:0] kh, logic [63:0] kl);
      pending_blocks.push_back(cipher_block(it, kh, kl));
    endfunction

    task check_block(aes128_pkg::out_item_t got);
      aes128_pkg::out_item_t exp_blk;
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      exp_blk = pending_blocks.pop_front();
      if (got.out_high !== exp_blk.out_high)
        report_mismatch($sformatf("out_high %h, want %h", got.out_high, exp_blk.out_high));
      if (got.out_low !== exp_blk.out_low)
        report_mismatch($sformatf("out_low %h, want %h", got.out_low, exp_blk.out_low));
    endtask
  endclass

  cipher_scoreboard sb;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_block(result_o);
      if (start_i && !busy_o) begin
        sb.note_block(data_i, key_hi, key_lo);
        n_blocks++;
        if (data_i.cmd == aes128_pkg::CMD_DECRYPT) n_dec++;
        else n_enc++;
      end
    end
  end

  task automatic drain();
    while (sb.pending_blocks.size() != 0) @(posedge clk_i);
    repeat (14) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [63:0] kh, input logic [63:0] kl);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= aes128_pkg::REG_KEY_HIGH;
    cfg_wdata_i <= kh;
    key_hi = kh;
    @(posedge clk_i);
    cfg_addr_i <= aes128_pkg::REG_KEY_LOW;
    cfg_wdata_i <= kl;
    key_lo = kl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_block(input logic c, input logic [63:0] bh, input logic [63:0] bl,
                            input bit may_idle);
    if (may_idle && $urandom_range(99) < 9) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    data_i <= '{cmd: c, block_high: bh, block_low: bl};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] kh_list [6];
    logic [63:0] kl_list [6];
    sb = new();
    n_errors = 0;
    n_blocks = 0;
    n_enc = 0;
    n_dec = 0;
    cycles = 0;
    key_hi = '0;
    key_lo = '0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    data_i = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = aes128_pkg::REG_KEY_HIGH;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key of zero, then the FIPS 197 example key.
    send_block(aes128_pkg::CMD_ENCRYPT, '0, '0, 1'b0);
    send_block(aes128_pkg::CMD_DECRYPT, '0, '0, 1'b0);
    send_block(aes128_pkg::CMD_ENCRYPT, '1, '1, 1'b0);
    send_block(aes128_pkg::CMD_DECRYPT, '1, '1, 1'b0);
    start_i <= 1'b0;
    drain();
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(aes128_pkg::CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(aes128_pkg::CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
    send_block(aes128_pkg::CMD_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001, 1'b0);
    send_block(aes128_pkg::CMD_DECRYPT, 64'h0000000000000001, 64'h8000000000000000, 1'b0);
    send_block(aes128_pkg::CMD_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
    send_block(aes128_pkg::CMD_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
    start_i <= 1'b0;
    drain();

    kh_list = '{64'hffffffffffffffff, 64'h0, 64'h2b7e151628aed2a6, 64'h0, 64'h0, 64'h0};
    kl_list = '{64'hffffffffffffffff, 64'h0, 64'habf7158809cf4f3c, 64'h0, 64'h0, 64'h0};
    for (int k = 3; k < 6; k++) begin
      kh_list[k] = rand64();
      kl_list[k] = rand64();
    end
    for (int k = 0; k < 6; k++) begin
      write_key(kh_list[k], kl_list[k]);
      for (int i = 0; i < 300; i++) begin
        send_block(1'($urandom_range(1)), rand64(), rand64(), k != 2);
      end
      start_i <= 1'b0;
      drain();
    end

    $display("Checked %0d blocks (%0d encrypt, %0d decrypt) under %0d keys.",
             n_blocks, n_enc, n_dec, 8);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: files.f
src/aes128_pkg.sv
src/aes128_round.sv
src/aes128_block_cipher.sv
dv/tb.sv
